>>> rtl/ppsc_pkg.sv
// Shared types and constants for the preemptive priority scheduler core.
package ppsc_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int SLOT_W    = $clog2(NUM_SLOTS);
   localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
   localparam int TIME_W    = 21;
   localparam int TCNT_W    = 5;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [3:0]  slot_index;
      logic [15:0] arrival_time;
      logic [15:0] burst_length;
      logic [7:0]  task_priority;
   } ppsc_request_type;

   typedef struct packed {
      logic [TIME_W-1:0] tick_time;
      logic              ran;
      logic [3:0]        run_slot;
      logic              finished;
      logic [TIME_W-1:0] completion_time;
      logic [TIME_W-1:0] turnaround_time;
      logic [TIME_W-1:0] waiting_time;
      logic              all_done;
   } ppsc_result_type;

   typedef struct packed {
      logic [15:0] arrival;
      logic [15:0] burst;
      logic [7:0]  prio;
      logic [15:0] remaining;
   } ppsc_entry_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] idx;
      ppsc_entry_type    entry;
   } ppsc_sel_type;

endpackage

>>> rtl/preemptive_priority_scheduler_core.sv
// Top level of the preemptive priority scheduler: sequencer, state and result register.
// Steps: a load writes its slot and goes straight to the result step; a tick reads each
// active slot through the shared compare unit, drains the last read, then runs the update
// and result steps. A tick after all tasks finish goes straight to the result step.
// Throughput: one request at a time; the next request is taken once the result is registered.
// Reset (synchronous, active high) clears tick, done count, task count and slot work.
module preemptive_priority_scheduler_core
   import ppsc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ppsc_request_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ppsc_result_type   rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [TCNT_W-1:0] csr_data
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_EXEC   = 5'b00100,
      ST_WAITC  = 5'b01000,
      ST_RESULT = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [TCNT_W-1:0] task_count_ff;
   logic [TIME_W-1:0] tick_ff, tick_in;
   logic [TIME_W-1:0] tick_next_ff, tick_next_in;
   logic [CNT_W-1:0]  done_ff, done_in;
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic              rd_pend_ff;
   logic [SLOT_W-1:0] rd_idx_ff;
   ppsc_result_type   res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ppsc_result_type   rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]  active_count;
   logic              all_done;
   logic              accept;
   logic              issue;
   logic              sel_clear;
   logic              out_free;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   ppsc_entry_type    wr_entry;
   logic [SLOT_W-1:0] rd_addr;
   ppsc_entry_type    rd_entry;
   ppsc_sel_type      sel;
   logic [15:0]       rem_dec;
   logic [TIME_W-1:0] burst_ext;

   // cap the task count at the slot count
   always_comb begin
      if (32'(task_count_ff) > NUM_SLOTS) begin
         active_count = CNT_W'(NUM_SLOTS);
      end else begin
         active_count = CNT_W'(task_count_ff);
      end
   end

   assign all_done  = done_ff >= active_count;
   assign req_stall = state_ff != ST_IDLE;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign issue     = (state_ff == ST_SCAN) && (issue_ff < active_count);
   assign rd_addr   = issue_ff[SLOT_W-1:0];
   assign sel_clear = accept;
   assign rem_dec   = sel.entry.remaining - 16'd1;
   assign burst_ext = {{(TIME_W-16){1'b0}}, sel.entry.burst};

   ppsc_task_store u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

   ppsc_select u_select (
      .clock       (clock),
      .clear       (sel_clear),
      .entry_valid (rd_pend_ff),
      .entry_idx   (rd_idx_ff),
      .entry       (rd_entry),
      .cur_tick    (tick_ff),
      .sel         (sel)
   );

   // sequence a load to result, a tick through scan, update and result
   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      tick_next_in = tick_next_ff;
      done_in      = done_ff;
      issue_in     = issue_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = SLOT_W'(req_data.slot_index);
      wr_entry     = '{arrival:   req_data.arrival_time,
                       burst:     req_data.burst_length,
                       prio:      req_data.task_priority,
                       remaining: req_data.burst_length};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in       = '0;
               issue_in     = '0;
               tick_next_in = (tick_ff == TIME_MAX) ? TIME_MAX : tick_ff + 1'b1;
               if (req_data.req_type == REQ_LOAD) begin
                  wr_en    = 32'(req_data.slot_index) < NUM_SLOTS;
                  tick_in  = '0;
                  done_in  = '0;
                  state_in = ST_RESULT;
               end else if (all_done) begin
                  res_in.tick_time = tick_ff;
                  state_in         = ST_RESULT;
               end else begin
                  res_in.tick_time = tick_ff;
                  state_in         = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               issue_in = issue_ff + 1'b1;
            end else if (!rd_pend_ff) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // run the chosen task for one tick and advance time
            tick_in = tick_next_ff;
            if (sel.found) begin
               wr_en              = 1'b1;
               wr_addr            = sel.idx;
               wr_entry           = sel.entry;
               wr_entry.remaining = rem_dec;
               res_in.ran         = 1'b1;
               res_in.run_slot    = 4'(sel.idx);
               if (rem_dec == '0) begin
                  res_in.finished        = 1'b1;
                  res_in.completion_time = tick_next_ff;
                  res_in.turnaround_time = tick_next_ff
                                           - {{(TIME_W-16){1'b0}}, sel.entry.arrival};
                  done_in                = done_ff + 1'b1;
               end
            end
            state_in = ST_WAITC;
         end
         ST_WAITC: begin
            if (res_ff.finished && (res_ff.turnaround_time >= burst_ext)) begin
               res_in.waiting_time = res_ff.turnaround_time - burst_ext;
            end
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in          = res_ff;
               rsp_data_in.all_done = all_done;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tick_ff       <= '0;
         done_ff       <= '0;
         task_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_pend_ff    <= 1'b0;
         issue_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= issue;
         issue_ff     <= issue_in;
         if (csr_valid && csr_ready) begin
            task_count_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tick_next_ff <= tick_next_in;
      rd_idx_ff    <= rd_addr;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/ppsc_task_store.sv
// Task slot memory with registered read and per-entry valid bits.
module ppsc_task_store
   import ppsc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [SLOT_W-1:0] wr_addr,
   input  ppsc_entry_type    wr_entry,
   input  logic [SLOT_W-1:0] rd_addr,
   output ppsc_entry_type    rd_entry
);

   ppsc_entry_type            mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]      valid_ff;
   ppsc_entry_type            rd_entry_ff;
   logic                      rd_valid_ff;

   // write the slot array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
   end

   // mark written slots; reset clears remaining work everywhere
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // register the read port
   always_ff @(posedge clock) begin
      rd_entry_ff <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   // an unwritten slot shows no remaining work
   always_comb begin
      rd_entry = rd_entry_ff;
      if (!rd_valid_ff) begin
         rd_entry.remaining = '0;
      end
   end

endmodule

>>> rtl/ppsc_select.sv
// Shared compare unit that tracks the best ready task over a slot scan.
module ppsc_select
   import ppsc_pkg::*;
(
   input  logic              clock,
   input  logic              clear,
   input  logic              entry_valid,
   input  logic [SLOT_W-1:0] entry_idx,
   input  ppsc_entry_type    entry,
   input  logic [TIME_W-1:0] cur_tick,
   output ppsc_sel_type      sel
);

   ppsc_sel_type sel_ff;
   ppsc_sel_type sel_in;
   logic         ready;
   logic         better;

   // ready means arrived with work left; strict compare keeps the lower slot on ties
   always_comb begin
      ready  = ({{(TIME_W-16){1'b0}}, entry.arrival} <= cur_tick) && (entry.remaining != '0);
      better = !sel_ff.found || (entry.prio < sel_ff.entry.prio);
      sel_in = sel_ff;
      if (clear) begin
         sel_in.found = 1'b0;
      end else if (entry_valid && ready && better) begin
         sel_in.found = 1'b1;
         sel_in.idx   = entry_idx;
         sel_in.entry = entry;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff <= sel_in;
   end

   assign sel = sel_ff;

endmodule
